>>> hdl/rrip_pkg.sv
// Shared types and constants for the RRIP signature/stream replacement block.
// Used by rrip_row_update and rrip_signature_stream_replacement; no dependencies.
`default_nettype none

package rrip_pkg;

   // Stream port layout
   localparam int REQ_DATA_W = 144;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 8;
   localparam int VICTIM_W   = 4;
   localparam int SET_IDX_W  = 11;
   localparam int WAY_IDX_W  = 4;
   localparam int ADDR_W     = 64;

   // Operation codes carried in req_tuser[0]
   localparam logic OP_VICTIM = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   // Age and counter limits
   localparam logic [1:0] AGE_MAX   = 2'd3;
   localparam logic [1:0] COUNT_MAX = 2'd3;
   localparam logic [1:0] SIG_INIT  = 2'd1;

   // Signature hash shifts
   localparam int HASH_SHIFT_LO = 13;
   localparam int HASH_SHIFT_HI = 23;

   // Set-dueling class stored with each set row
   localparam logic [1:0] CLS_NONE = 2'd0;
   localparam logic [1:0] CLS_NEAR = 2'd1;
   localparam logic [1:0] CLS_DEEP = 2'd2;

   // Per-access control handed to the row update logic
   typedef struct packed {
      logic update;     // access update, not a victim request
      logic hit;        // update came from a hit
      logic streaming;  // repeated nonzero stride seen on this miss
      logic sig_hot;    // signature counter above one
      logic sel_deep;   // dueling selector favors the near-distant insert
   } upd_ctl_type;

endpackage

`default_nettype wire

>>> hdl/rrip_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies; used for the set row store and the signature counters.
`default_nettype none

module rrip_ram #(
   parameter int DEPTH = 2048,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> hdl/rrip_row_update.sv
// Victim selection and age/dead-count update for one set row.
// Depends on rrip_pkg for age limits and the control struct.
`default_nettype none

module rrip_row_update #(
   parameter int NUM_WAYS = 16
) (
   input  wire logic [NUM_WAYS*2-1:0]       age_row,
   input  wire logic [NUM_WAYS*2-1:0]       dead_row,
   input  wire logic [$clog2(NUM_WAYS)-1:0] way,
   input  wire rrip_pkg::upd_ctl_type       ctl,
   output logic      [NUM_WAYS*2-1:0]       new_age_row,
   output logic      [NUM_WAYS*2-1:0]       new_dead_row,
   output logic      [$clog2(NUM_WAYS)-1:0] victim
);

   localparam int WAY_W = $clog2(NUM_WAYS);

   logic                  any3;
   logic                  any2;
   logic                  any1;
   logic [1:0]            oldest;
   logic [1:0]            lift;
   logic [NUM_WAYS*2-1:0] lifted;
   logic                  found_live;
   logic [WAY_W-1:0]      victim_live;
   logic [WAY_W-1:0]      victim_old;
   logic [1:0]            ins_age;
   logic [1:0]            ins_dead;

   // oldest age in the row and the lift that brings it to distant
   always_comb begin
      any3 = 1'b0;
      any2 = 1'b0;
      any1 = 1'b0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         any3 = any3 | (age_row[w*2 +: 2] == 2'd3);
         any2 = any2 | (age_row[w*2 +: 2] == 2'd2);
         any1 = any1 | (age_row[w*2 +: 2] == 2'd1);
      end
      if (any3) begin
         oldest = 2'd3;
      end else if (any2) begin
         oldest = 2'd2;
      end else if (any1) begin
         oldest = 2'd1;
      end else begin
         oldest = 2'd0;
      end
      lift = rrip_pkg::AGE_MAX - oldest;
      for (int w = 0; w < NUM_WAYS; w++) begin
         lifted[w*2 +: 2] = age_row[w*2 +: 2] + lift;
      end
   end

   // first distant way with zero dead count, else first distant way
   always_comb begin
      found_live  = 1'b0;
      victim_live = '0;
      victim_old  = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (lifted[w*2 +: 2] == rrip_pkg::AGE_MAX) begin
            victim_old = WAY_W'(w);
            if (dead_row[w*2 +: 2] == 2'd0) begin
               victim_live = WAY_W'(w);
               found_live  = 1'b1;
            end
         end
      end
      victim = found_live ? victim_live : victim_old;
   end

   // insertion or promotion values for the touched way
   always_comb begin
      if (ctl.hit) begin
         ins_age  = 2'd0;
         ins_dead = rrip_pkg::COUNT_MAX;
      end else if (ctl.streaming) begin
         ins_age  = rrip_pkg::AGE_MAX;
         ins_dead = 2'd0;
      end else if (ctl.sig_hot) begin
         ins_age  = 2'd0;
         ins_dead = rrip_pkg::COUNT_MAX;
      end else begin
         ins_age  = ctl.sel_deep ? (rrip_pkg::AGE_MAX - 2'd1) : rrip_pkg::AGE_MAX;
         ins_dead = rrip_pkg::COUNT_MAX;
      end
   end

   // new row contents
   always_comb begin
      if (!ctl.update) begin
         new_age_row  = lifted;
         new_dead_row = dead_row;
      end else begin
         new_age_row  = age_row;
         new_dead_row = dead_row;
         for (int w = 0; w < NUM_WAYS; w++) begin
            if (way == WAY_W'(w)) begin
               new_age_row[w*2 +: 2]  = ins_age;
               new_dead_row[w*2 +: 2] = ins_dead;
            end
         end
      end
   end

endmodule

`default_nettype wire

>>> hdl/rrip_signature_stream_replacement.sv
// A victim result is registered into rsp_tvalid when its request leaves the execute state;
// a request transfer moves the controller from idle to execute and issues the set row read.
// A new request is taken only in idle, after the previous item has written back the set row
// memory; a victim request waits in execute while the previous result is not taken.
// Reset: synchronous; a clearing pass over max(NUM_SETS, 2**SIGNATURE_BITS) addresses
// (2048 by default) initializes both memories while req_tready stays low.
// Depends on rrip_pkg, rrip_ram and rrip_row_update.
`default_nettype none

module rrip_signature_stream_replacement #(
   parameter int NUM_SETS           = 2048,
   parameter int NUM_WAYS           = 16,
   parameter int SIGNATURE_BITS     = 10,
   parameter int DUEL_GROUP         = 64,
   parameter int LEADERS_PER_POLICY = 32,
   parameter int SELECTOR_MAX       = 1023
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [10:0] set_index, [14:11] way_index, [78:15] pc, [142:79] address, [143] zero
   input  wire logic [rrip_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] operation, [1] hit
   input  wire logic [rrip_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [3:0] victim_way, [7:4] zero
   output logic      [rrip_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int SET_AW      = $clog2(NUM_SETS);
   localparam int SUM_W       = SET_AW + 1;
   localparam int WAY_W       = $clog2(NUM_WAYS);
   localparam int SIG_ENTRIES = 1 << SIGNATURE_BITS;
   localparam int CLR_DEPTH   = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
   localparam int CLR_W       = $clog2(CLR_DEPTH);
   localparam int CLR_CW      = CLR_W + 1;
   localparam int SEL_W       = $clog2(SELECTOR_MAX + 1);
   localparam int SLOT_W      = $clog2(DUEL_GROUP);
   localparam int ROW_W       = NUM_WAYS * 2;
   localparam int AW          = rrip_pkg::ADDR_W;
   localparam int PA_LO       = 2 * ROW_W;
   localparam int PD_LO       = PA_LO + AW;
   localparam int CLS_LO      = PD_LO + AW;
   localparam int WORD_W      = CLS_LO + 2;
   localparam int LO_BITS     = 6;
   localparam int HI_N        = 1 << (rrip_pkg::SET_IDX_W - LO_BITS);
   localparam int WAY_N       = 1 << rrip_pkg::WAY_IDX_W;

   localparam logic [SEL_W-1:0]  SEL_MAX  = SEL_W'(SELECTOR_MAX);
   localparam logic [SEL_W-1:0]  SEL_MID  = SEL_W'(SELECTOR_MAX / 2);
   localparam logic [SUM_W-1:0]  SET_LIM  = SUM_W'(NUM_SETS);
   localparam logic [CLR_CW-1:0] CLR_SETS = CLR_CW'(NUM_SETS);
   localparam logic [CLR_CW-1:0] CLR_SIGS = CLR_CW'(SIG_ENTRIES);
   localparam logic [CLR_W-1:0]  CLR_LAST = CLR_W'(CLR_DEPTH - 1);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(DUEL_GROUP - 1);
   localparam logic [31:0]       NEAR_LIM = 32'(LEADERS_PER_POLICY);
   localparam logic [31:0]       DEEP_LIM = 32'(2 * LEADERS_PER_POLICY);

   // controller states
   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   // request fields
   logic [rrip_pkg::SET_IDX_W-1:0] req_set_index;
   logic [rrip_pkg::WAY_IDX_W-1:0] req_way_index;
   logic [63:0]                    req_pc;
   logic [AW-1:0]                  req_address;
   logic                           req_operation;
   logic                           req_hit;

   assign req_set_index = req_tdata[10:0];
   assign req_way_index = req_tdata[14:11];
   assign req_pc        = req_tdata[78:15];
   assign req_address   = req_tdata[142:79];
   assign req_operation = req_tuser[0];
   assign req_hit       = req_tuser[1];

   // control and payload registers
   logic [1:0]                   state_ff, state_in;
   logic [CLR_W-1:0]             clr_ff, clr_in;
   logic [SLOT_W-1:0]            slot_ff, slot_in;
   logic [SEL_W-1:0]             sel_ff, sel_in;
   logic                         rsp_tvalid_ff, rsp_tvalid_in;
   logic [rrip_pkg::VICTIM_W-1:0] rsp_data_ff;
   logic                         op_ff;
   logic                         hit_ff;
   logic [SET_AW-1:0]            set_ff;
   logic [WAY_W-1:0]             way_ff;
   logic [SIGNATURE_BITS-1:0]    sig_ff;
   logic [AW-1:0]                addr_ff;

   logic                         accept;
   logic                         clearing;
   logic                         exec_fire;
   logic                         miss_update;

   // set index modulo NUM_SETS: constant base per upper bits plus low bits
   logic [SET_AW-1:0] set_base [HI_N];
   logic [SUM_W-1:0]  set_sum;
   logic [SET_AW-1:0] set_mod;

   for (genvar h = 0; h < HI_N; h++) begin : g_set_base
      localparam int BASE = (h * 64) % NUM_SETS;
      assign set_base[h] = SET_AW'(BASE);
   end

   assign set_sum = {1'b0, set_base[req_set_index[rrip_pkg::SET_IDX_W-1:LO_BITS]]}
                  + SUM_W'(req_set_index[LO_BITS-1:0]);
   assign set_mod = (set_sum >= SET_LIM) ? SET_AW'(set_sum - SET_LIM) : SET_AW'(set_sum);

   // way index modulo NUM_WAYS
   logic [WAY_W-1:0] way_mod [WAY_N];

   for (genvar g = 0; g < WAY_N; g++) begin : g_way_mod
      localparam int WMOD = g % NUM_WAYS;
      assign way_mod[g] = WAY_W'(WMOD);
   end

   // signature hash
   logic [63:0]               hash_full;
   logic [SIGNATURE_BITS-1:0] req_sig;

   assign hash_full = req_pc ^ (req_pc >> rrip_pkg::HASH_SHIFT_LO)
                    ^ (req_pc >> rrip_pkg::HASH_SHIFT_HI);
   assign req_sig   = hash_full[SIGNATURE_BITS-1:0];

   // handshake and sequencing
   assign clearing    = (state_ff == ST_CLEAR);
   assign req_tready  = (state_ff == ST_IDLE);
   assign accept      = req_tvalid && req_tready;
   assign exec_fire   = (state_ff == ST_EXEC)
                     && ((op_ff == rrip_pkg::OP_UPDATE) || !rsp_tvalid_ff || rsp_tready);
   assign miss_update = (op_ff == rrip_pkg::OP_UPDATE) && !hit_ff;

   // set row memory
   logic              set_we;
   logic [SET_AW-1:0] set_waddr;
   logic [WORD_W-1:0] set_wdata;
   logic [WORD_W-1:0] set_rdata;
   logic [WORD_W-1:0] clear_word;
   logic [WORD_W-1:0] exec_word;
   logic              clr_in_sets;
   logic [1:0]        clr_cls;
   logic [31:0]       slot_wide;

   assign clr_in_sets = {1'b0, clr_ff} < CLR_SETS;
   assign slot_wide   = 32'(slot_ff);

   // leader class of the set being cleared
   always_comb begin
      if (slot_wide < NEAR_LIM) begin
         clr_cls = rrip_pkg::CLS_NEAR;
      end else if (slot_wide < DEEP_LIM) begin
         clr_cls = rrip_pkg::CLS_DEEP;
      end else begin
         clr_cls = rrip_pkg::CLS_NONE;
      end
   end

   assign clear_word = {clr_cls, {AW{1'b0}}, {AW{1'b0}}, {ROW_W{1'b0}}, {ROW_W{1'b1}}};
   assign set_we     = clearing ? clr_in_sets : exec_fire;
   assign set_waddr  = clearing ? clr_ff[SET_AW-1:0] : set_ff;
   assign set_wdata  = clearing ? clear_word : exec_word;

   rrip_ram #(
      .DEPTH (NUM_SETS),
      .WIDTH (WORD_W)
   ) u_set_ram (
      .clock (clock),
      .we    (set_we),
      .waddr (set_waddr),
      .wdata (set_wdata),
      .re    (accept),
      .raddr (set_mod),
      .rdata (set_rdata)
   );

   // signature counter memory
   logic                      clr_in_sigs;
   logic                      sig_we;
   logic [SIGNATURE_BITS-1:0] sig_waddr;
   logic [1:0]                sig_wdata;
   logic [1:0]                sig_rdata;
   logic [1:0]                sig_inc;

   assign clr_in_sigs = {1'b0, clr_ff} < CLR_SIGS;
   assign sig_inc     = (sig_rdata == rrip_pkg::COUNT_MAX) ? rrip_pkg::COUNT_MAX
                                                           : sig_rdata + 2'd1;
   assign sig_we      = clearing ? clr_in_sigs
                                 : (exec_fire && (op_ff == rrip_pkg::OP_UPDATE) && hit_ff);
   assign sig_waddr   = clearing ? clr_ff[SIGNATURE_BITS-1:0] : sig_ff;
   assign sig_wdata   = clearing ? rrip_pkg::SIG_INIT : sig_inc;

   rrip_ram #(
      .DEPTH (SIG_ENTRIES),
      .WIDTH (2)
   ) u_sig_ram (
      .clock (clock),
      .we    (sig_we),
      .waddr (sig_waddr),
      .wdata (sig_wdata),
      .re    (accept),
      .raddr (req_sig),
      .rdata (sig_rdata)
   );

   // row fields read back for the item in execute
   logic [ROW_W-1:0] age_row;
   logic [ROW_W-1:0] dead_row;
   logic [AW-1:0]    prev_addr;
   logic [AW-1:0]    prev_delta;
   logic [1:0]       row_cls;
   logic [AW-1:0]    delta;
   logic             streaming;
   logic [SEL_W-1:0] sel_adj;

   assign age_row    = set_rdata[ROW_W-1:0];
   assign dead_row   = set_rdata[PA_LO-1:ROW_W];
   assign prev_addr  = set_rdata[PA_LO +: AW];
   assign prev_delta = set_rdata[PD_LO +: AW];
   assign row_cls    = set_rdata[CLS_LO +: 2];

   // stride detector
   assign delta     = (prev_addr != '0) ? (addr_ff - prev_addr) : '0;
   assign streaming = (delta != '0) && (delta == prev_delta);

   // dueling selector step for a miss in a leader set
   always_comb begin
      case (row_cls)
         rrip_pkg::CLS_NEAR: sel_adj = (sel_ff != '0) ? sel_ff - SEL_W'(1) : sel_ff;
         rrip_pkg::CLS_DEEP: sel_adj = (sel_ff < SEL_MAX) ? sel_ff + SEL_W'(1) : sel_ff;
         default:            sel_adj = sel_ff;
      endcase
   end

   assign sel_in = (exec_fire && miss_update) ? sel_adj : sel_ff;

   // row update
   rrip_pkg::upd_ctl_type upd_ctl;
   logic [ROW_W-1:0]      new_age_row;
   logic [ROW_W-1:0]      new_dead_row;
   logic [WAY_W-1:0]      victim;
   logic [AW-1:0]         new_pa;
   logic [AW-1:0]         new_pd;

   assign upd_ctl.update    = (op_ff == rrip_pkg::OP_UPDATE);
   assign upd_ctl.hit       = hit_ff;
   assign upd_ctl.streaming = streaming;
   assign upd_ctl.sig_hot   = sig_rdata > rrip_pkg::SIG_INIT;
   assign upd_ctl.sel_deep  = sel_adj >= SEL_MID;

   rrip_row_update #(
      .NUM_WAYS (NUM_WAYS)
   ) u_row_update (
      .age_row      (age_row),
      .dead_row     (dead_row),
      .way          (way_ff),
      .ctl          (upd_ctl),
      .new_age_row  (new_age_row),
      .new_dead_row (new_dead_row),
      .victim       (victim)
   );

   assign new_pa    = miss_update ? addr_ff : prev_addr;
   assign new_pd    = miss_update ? delta : prev_delta;
   assign exec_word = {row_cls, new_pd, new_pa, new_dead_row, new_age_row};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_ff == CLR_LAST) state_in = ST_IDLE;
         ST_IDLE:  if (accept) state_in = ST_EXEC;
         ST_EXEC:  if (exec_fire) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // clearing sweep counters
   assign clr_in  = clearing ? clr_ff + CLR_W'(1) : clr_ff;
   assign slot_in = !clearing ? slot_ff
                  : (slot_ff == SLOT_LAST) ? '0 : slot_ff + SLOT_W'(1);

   // result register
   assign rsp_tvalid_in = (rsp_tvalid_ff && !rsp_tready)
                       || (exec_fire && (op_ff == rrip_pkg::OP_VICTIM));

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         slot_ff       <= '0;
         sel_ff        <= SEL_MID;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         slot_ff       <= slot_in;
         sel_ff        <= sel_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_operation;
         hit_ff  <= req_hit;
         set_ff  <= set_mod;
         way_ff  <= way_mod[req_way_index];
         sig_ff  <= req_sig;
         addr_ff <= req_address;
      end
      if (exec_fire && (op_ff == rrip_pkg::OP_VICTIM)) begin
         rsp_data_ff <= rrip_pkg::VICTIM_W'(victim);
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(rrip_pkg::RSP_DATA_W - rrip_pkg::VICTIM_W){1'b0}}, rsp_data_ff};

   // a result only appears after a victim request finishes execute
   a_rsp_from_victim : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(exec_fire && (op_ff == rrip_pkg::OP_VICTIM)))
      else $error("result raised without a completed victim request");

   // updates never wait on the result channel
   a_update_no_stall : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EXEC) && (op_ff == rrip_pkg::OP_UPDATE)) |-> exec_fire)
      else $error("update stalled in execute");

   // chosen victim is distant in the written-back row
   a_victim_distant : assert property (@(posedge clock) disable iff (reset)
      (exec_fire && (op_ff == rrip_pkg::OP_VICTIM))
         |-> (new_age_row[{victim, 1'b0} +: 2] == rrip_pkg::AGE_MAX))
      else $error("victim way is not at the distant age");

   // selector stays within its range
   a_sel_range : assert property (@(posedge clock) disable iff (reset)
      sel_ff <= SEL_MAX)
      else $error("dueling selector out of range");

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for rrip_signature_stream_replacement: stream requests in, victims out.
// Predicts every victim with its own copy of the replacement state. Depends on rrip_pkg.
`timescale 1ns / 1ps

module testbench;

   localparam int NUM_SETS           = 2048;
   localparam int NUM_WAYS           = 16;
   localparam int SIGNATURE_BITS     = 10;
   localparam int DUEL_GROUP         = 64;
   localparam int LEADERS_PER_POLICY = 32;
   localparam int SELECTOR_MAX       = 1023;
   localparam int CYCLE_LIMIT        = 600000;
   localparam int HOLD_CYCLES        = 400;
   localparam int DRAIN_CYCLES       = 20;

   // shared layout and codes
   localparam int         REQ_DATA_W    = rrip_pkg::REQ_DATA_W;
   localparam int         REQ_USER_W    = rrip_pkg::REQ_USER_W;
   localparam int         RSP_DATA_W    = rrip_pkg::RSP_DATA_W;
   localparam int         VICTIM_W      = rrip_pkg::VICTIM_W;
   localparam int         HASH_SHIFT_LO = rrip_pkg::HASH_SHIFT_LO;
   localparam int         HASH_SHIFT_HI = rrip_pkg::HASH_SHIFT_HI;
   localparam logic       OP_VICTIM     = rrip_pkg::OP_VICTIM;
   localparam logic       OP_UPDATE     = rrip_pkg::OP_UPDATE;
   localparam logic [1:0] AGE_MAX       = rrip_pkg::AGE_MAX;
   localparam logic [1:0] COUNT_MAX     = rrip_pkg::COUNT_MAX;
   localparam logic [1:0] SIG_INIT      = rrip_pkg::SIG_INIT;

   localparam logic ACC_HIT   = 1'b1;
   localparam logic ACC_MISS  = 1'b0;
   localparam logic TYPED     = 1'b1;
   localparam logic PREDICTED = 1'b0;

   localparam logic [63:0] PC_A     = 64'h0000_0040_1234_5678;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   // one row of directed stimulus
   typedef struct packed {
      logic        op;
      logic [10:0] set_idx;
      logic [3:0]  way;
      logic        hit;
      logic [63:0] pc;
      logic [63:0] addr;
      logic        typed;
      logic [3:0]  victim;
   } access_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // predicted replacement state
   logic [1:0]  row_age      [NUM_SETS][NUM_WAYS];
   logic [1:0]  row_dead     [NUM_SETS][NUM_WAYS];
   logic [1:0]  sig_strength [1 << SIGNATURE_BITS];
   int          duel_sel;
   logic [63:0] last_addr    [NUM_SETS];
   logic [63:0] last_delta   [NUM_SETS];

   // stride streams the stimulus follows per set
   logic [63:0] stream_addr   [NUM_SETS];
   logic [63:0] stream_stride [NUM_SETS];
   logic [63:0] pc_pool       [8];

   logic [VICTIM_W-1:0] victims_due [$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int accesses_sent  = 0;
   int victims_sent   = 0;
   int victims_seen   = 0;
   int lifts_seen     = 0;
   int stream_fills   = 0;
   bit sel_hit_floor  = 0;
   bit sel_hit_top    = 0;
   bit steady         = 0;
   bit hold_request   = 0;

   access_row_type directed_rows [0:18] = '{
      '{OP_VICTIM, 11'd0,    4'd0,  ACC_MISS, 64'd0,    64'd0,                 TYPED,     4'd0},
      '{OP_VICTIM, 11'd2047, 4'd0,  ACC_MISS, ALL_ONES, ALL_ONES,              TYPED,     4'd0},
      '{OP_UPDATE, 11'd0,    4'd0,  ACC_HIT,  PC_A,     64'd0,                 PREDICTED, 4'd0},
      '{OP_VICTIM, 11'd0,    4'd0,  ACC_MISS, 64'd0,    64'd0,                 TYPED,     4'd1},
      '{OP_UPDATE, 11'd0,    4'd15, ACC_MISS, ALL_ONES, 64'h1000,              PREDICTED, 4'd0},
      '{OP_UPDATE, 11'd0,    4'd1,  ACC_MISS, 64'd0,    64'h1040,              PREDICTED, 4'd0},
      '{OP_UPDATE, 11'd0,    4'd2,  ACC_MISS, 64'd0,    64'h1080,              PREDICTED, 4'd0},
      '{OP_VICTIM, 11'd0,    4'd0,  ACC_MISS, 64'd0,    64'd0,                 PREDICTED, 4'd0},
      '{OP_UPDATE, 11'd0,    4'd2,  ACC_HIT,  PC_A,     64'd0,                 PREDICTED, 4'd0},
      '{OP_UPDATE, 11'd1,    4'd3,  ACC_HIT,  PC_A,     64'd0,                 PREDICTED, 4'd0},
      '{OP_UPDATE, 11'd32,   4'd4,  ACC_MISS, PC_A,     ALL_ONES,              PREDICTED, 4'd0},
      '{OP_UPDATE, 11'd2047, 4'd15, ACC_MISS, ALL_ONES, ALL_ONES,              PREDICTED, 4'd0},
      '{OP_UPDATE, 11'd2047, 4'd14, ACC_MISS, ALL_ONES, ALL_ONES - 64'h40,     PREDICTED, 4'd0},
      '{OP_UPDATE, 11'd2047, 4'd13, ACC_MISS, ALL_ONES, ALL_ONES - 64'h80,     PREDICTED, 4'd0},
      '{OP_UPDATE, 11'd2047, 4'd12, ACC_MISS, ALL_ONES, ALL_ONES - 64'h80,     PREDICTED, 4'd0},
      '{OP_VICTIM, 11'd2047, 4'd0,  ACC_MISS, 64'd0,    64'd0,                 PREDICTED, 4'd0},
      '{OP_UPDATE, 11'd5,    4'd0,  ACC_MISS, 64'd0,    64'd0,                 PREDICTED, 4'd0},
      '{OP_VICTIM, 11'd5,    4'd0,  ACC_MISS, 64'd0,    64'd0,                 PREDICTED, 4'd0},
      '{OP_VICTIM, 11'd1,    4'd0,  ACC_MISS, 64'd0,    64'd0,                 PREDICTED, 4'd0}
   };

   rrip_signature_stream_replacement dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // victim choice: age the set if nobody is distant, then prefer distant ways not marked used
   function automatic logic [VICTIM_W-1:0] choose_victim(input logic [10:0] s);
      logic [1:0] oldest;
      logic [1:0] lift;
      logic [VICTIM_W-1:0] pick;
      bit found;
      oldest = 2'd0;
      pick   = '0;
      found  = 0;
      for (int w = 0; w < NUM_WAYS; w++)
         if (row_age[s][w] > oldest) oldest = row_age[s][w];
      if (oldest < AGE_MAX) begin
         lift = AGE_MAX - oldest;
         lifts_seen++;
         for (int w = 0; w < NUM_WAYS; w++) row_age[s][w] = row_age[s][w] + lift;
      end
      for (int w = 0; w < NUM_WAYS; w++)
         if (!found && row_age[s][w] == AGE_MAX && row_dead[s][w] == 2'd0) begin
            pick  = w[VICTIM_W-1:0];
            found = 1;
         end
      for (int w = 0; w < NUM_WAYS; w++)
         if (!found && row_age[s][w] == AGE_MAX) begin
            pick  = w[VICTIM_W-1:0];
            found = 1;
         end
      return pick;
   endfunction

   // hit promotion or miss insertion, with dueling and stride tracking on misses
   function automatic void apply_access(input logic [10:0] s, input logic [3:0] way,
                                        input logic hit, input logic [63:0] pc,
                                        input logic [63:0] addr);
      logic [63:0] hash;
      logic [SIGNATURE_BITS-1:0] sig;
      logic [63:0] delta;
      bit streaming;
      int slot;
      hash = pc ^ (pc >> HASH_SHIFT_LO) ^ (pc >> HASH_SHIFT_HI);
      sig  = hash[SIGNATURE_BITS-1:0];
      if (hit == ACC_HIT) begin
         row_age[s][way] = 2'd0;
         if (sig_strength[sig] < COUNT_MAX) sig_strength[sig] = sig_strength[sig] + 2'd1;
         row_dead[s][way] = COUNT_MAX;
         return;
      end
      slot = int'(s) % DUEL_GROUP;
      if (slot < LEADERS_PER_POLICY) begin
         if (duel_sel > 0) duel_sel--;
      end else if (slot < 2 * LEADERS_PER_POLICY) begin
         if (duel_sel < SELECTOR_MAX) duel_sel++;
      end
      if (duel_sel == 0) sel_hit_floor = 1;
      if (duel_sel == SELECTOR_MAX) sel_hit_top = 1;
      delta = (last_addr[s] != 64'd0) ? addr - last_addr[s] : 64'd0;
      streaming = (delta != 64'd0) && (delta == last_delta[s]);
      last_delta[s] = delta;
      last_addr[s]  = addr;
      if (streaming) begin
         stream_fills++;
         row_age[s][way]  = AGE_MAX;
         row_dead[s][way] = 2'd0;
      end else if (sig_strength[sig] > 2'd1) begin
         row_age[s][way]  = 2'd0;
         row_dead[s][way] = COUNT_MAX;
      end else begin
         row_age[s][way]  = (duel_sel >= SELECTOR_MAX / 2) ? AGE_MAX - 2'd1 : AGE_MAX;
         row_dead[s][way] = COUNT_MAX;
      end
   endfunction

   // mostly a small pool of leader sets of one class, now and then any set
   function automatic logic [10:0] pick_set(input bit toward_deep);
      logic [4:0] group;
      logic [5:0] slot;
      if ($urandom_range(0, 99) < 4) return 11'($urandom_range(0, NUM_SETS - 1));
      case ($urandom_range(0, 2))
         0: group = 5'd0;
         1: group = 5'd1;
         default: group = 5'd31;
      endcase
      case ($urandom_range(0, 2))
         0: slot = toward_deep ? 6'd32 : 6'd0;
         1: slot = toward_deep ? 6'd50 : 6'd9;
         default: slot = toward_deep ? 6'd63 : 6'd31;
      endcase
      return {group, slot};
   endfunction

   function automatic logic [63:0] pick_pc();
      if ($urandom_range(0, 99) < 65) return pc_pool[$urandom_range(0, 7)];
      return {$urandom, $urandom};
   endfunction

   // fill address: mostly the next step of the set's stride, sometimes a break
   function automatic logic [63:0] next_address(input logic [10:0] s);
      int r;
      logic [63:0] a;
      r = $urandom_range(0, 99);
      if (stream_stride[s] == 64'd0 || r < 6) begin
         case ($urandom_range(0, 3))
            0: stream_stride[s] = 64'd64;
            1: stream_stride[s] = 64'hFFFF_FFFF_FFFF_FFC0;
            2: stream_stride[s] = 64'd4096;
            default: stream_stride[s] = {$urandom, $urandom};
         endcase
      end
      if (r < 70)      a = stream_addr[s] + stream_stride[s];
      else if (r < 78) a = stream_addr[s];
      else if (r < 82) a = 64'd0;
      else             a = {$urandom, $urandom};
      stream_addr[s] = a;
      return a;
   endfunction

   // offer one access, wait for its transfer, then update the prediction
   task automatic send_access(input logic op, input logic [10:0] s, input logic [3:0] way,
                              input logic hit, input logic [63:0] pc, input logic [63:0] addr,
                              input logic typed, input logic [3:0] typed_way,
                              output logic [3:0] victim);
      victim = '0;
      if (!steady && $urandom_range(0, 99) < 26) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, addr, pc, way, s};
      req_tuser  <= {hit, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      accesses_sent++;
      if (op == OP_VICTIM) begin
         victim = choose_victim(s);
         victims_sent++;
         victims_due.push_back(typed ? typed_way : victim);
      end else begin
         apply_access(s, way, hit, pc, addr);
      end
   endtask

   // one random step: victim plus fill, a lone fill, a hit, or noise
   task automatic random_step(input bit toward_deep);
      int r;
      logic [10:0] s;
      logic [3:0] v;
      logic [3:0] unused_way;
      logic [63:0] pc;
      r  = $urandom_range(0, 99);
      s  = pick_set(toward_deep);
      pc = pick_pc();
      if (r < 22) begin
         send_access(OP_VICTIM, s, 4'($urandom), 1'($urandom), pc, {$urandom, $urandom},
                     PREDICTED, '0, v);
         send_access(OP_UPDATE, s, v, ACC_MISS, pc, next_address(s), PREDICTED, '0,
                     unused_way);
      end else if (r < 88) begin
         send_access(OP_UPDATE, s, 4'($urandom), ACC_MISS, pc, next_address(s), PREDICTED,
                     '0, unused_way);
      end else if (r < 96) begin
         send_access(OP_UPDATE, s, 4'($urandom), ACC_HIT, pc, {$urandom, $urandom},
                     PREDICTED, '0, unused_way);
      end else begin
         send_access(1'($urandom), 11'($urandom), 4'($urandom), 1'($urandom),
                     {$urandom, $urandom}, {$urandom, $urandom}, PREDICTED, '0, unused_way);
      end
   endtask

   // drive the selector to one limit, then a little further
   task automatic run_stage(input bit toward_deep, input int cap, input int steady_steps);
      int extra;
      extra = 0;
      for (int n = 0; n < cap && extra < 20; n++) begin
         steady = (n < steady_steps);
         random_step(toward_deep);
         if (duel_sel == (toward_deep ? SELECTOR_MAX : 0)) extra++;
      end
      steady = 0;
   endtask

   // predictor reset and stimulus
   initial begin : stimulus
      logic [3:0] v;
      for (int s = 0; s < NUM_SETS; s++) begin
         for (int w = 0; w < NUM_WAYS; w++) begin
            row_age[s][w]  = AGE_MAX;
            row_dead[s][w] = 2'd0;
         end
         last_addr[s]     = 64'd0;
         last_delta[s]    = 64'd0;
         stream_addr[s]   = 64'd0;
         stream_stride[s] = 64'd0;
      end
      for (int i = 0; i < (1 << SIGNATURE_BITS); i++) sig_strength[i] = SIG_INIT;
      duel_sel = SELECTOR_MAX / 2;
      for (int i = 0; i < 8; i++) pc_pool[i] = {$urandom, $urandom};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed rows
      foreach (directed_rows[i])
         send_access(directed_rows[i].op, directed_rows[i].set_idx, directed_rows[i].way,
                     directed_rows[i].hit, directed_rows[i].pc, directed_rows[i].addr,
                     directed_rows[i].typed, directed_rows[i].victim, v);

      // near leaders first, starting with a stretch of no idling
      run_stage(1'b0, 1600, 250);

      // sender pauses until every victim is back
      req_tvalid <= 1'b0;
      while (victims_due.size() != 0) @(posedge clock);

      // deep leaders, with the receiver holding off at the start
      hold_request = 1;
      run_stage(1'b1, 2600, 0);

      req_tvalid <= 1'b0;
      while (victims_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d accesses (%0d victim requests), checked %0d victim results.",
               accesses_sent, victims_sent, victims_seen);
      $display("Saw %0d age lifts, %0d streaming fills; selector at 0: %0d, at max: %0d.",
               lifts_seen, stream_fills, sel_hit_floor, sel_hit_top);
      if (mismatch_count == 0 && victims_due.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // result side ready: random stalls, steady stretches and one long hold-off
   initial begin : result_sink
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(0, 99) >= 26);
         end
      end
   end

   // compare each result transfer with the oldest predicted victim
   always @(posedge clock) begin : result_check
      logic [VICTIM_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         victims_seen++;
         if (victims_due.size() == 0) begin
            $error("unexpected result: victim_way %0d", rsp_tdata[VICTIM_W-1:0]);
            mismatch_count++;
         end else begin
            want = victims_due.pop_front();
            if (rsp_tdata[VICTIM_W-1:0] !== want) begin
               $error("victim_way mismatch: expected %0d, actual %0d", want,
                      rsp_tdata[VICTIM_W-1:0]);
               mismatch_count++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
                  victims_due.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule

>>> sim.f
hdl/rrip_pkg.sv
hdl/rrip_ram.sv
hdl/rrip_row_update.sv
hdl/rrip_signature_stream_replacement.sv
bench/testbench.sv
